FILE: rtl/core/necir_pkg.sv
// Shared types and constants of the NEC infrared pulse decoder.
package necir_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned WIN_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [WIN_W-1:0]     win_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LEAD_SILENCE = 3'd0;
  localparam cfg_idx_t REG_LEAD_PULSE   = 3'd1;
  localparam cfg_idx_t REG_REPEAT_PULSE = 3'd2;
  localparam cfg_idx_t REG_BIT_SILENCE  = 3'd3;
  localparam cfg_idx_t REG_ZERO_PULSE   = 3'd4;
  localparam cfg_idx_t REG_ONE_PULSE    = 3'd5;

  localparam win_t RST_LEAD_SILENCE = 32'd655368000;
  localparam win_t RST_LEAD_PULSE   = 32'd327684000;
  localparam win_t RST_REPEAT_PULSE = 32'd163842000;
  localparam win_t RST_BIT_SILENCE  = 32'd47186320;
  localparam win_t RST_ZERO_PULSE   = 32'd47186320;
  localparam win_t RST_ONE_PULSE    = 32'd131073400;

  typedef struct packed {
    win_t lead_silence_window;
    win_t lead_pulse_window;
    win_t repeat_pulse_window;
    win_t bit_silence_window;
    win_t zero_pulse_window;
    win_t one_pulse_window;
  } necir_cfg_t;

  typedef struct packed {
    code_t code_word;
    logic  is_repeat;
    logic  frame_done;
  } necir_result_t;

endpackage

FILE: rtl/core/necir_ifs.sv
// Channel interfaces of the NEC infrared pulse decoder.
interface necir_in_if;
  import necir_pkg::*;
  logic  valid;
  logic  ready;
  tick_t edge_time;
  logic  last_edge;
  modport source (output valid, output edge_time, output last_edge, input ready);
  modport sink (input valid, input edge_time, input last_edge, output ready);
endinterface

interface necir_out_if;
  import necir_pkg::*;
  logic  valid;
  logic  ready;
  code_t code_word;
  logic  is_repeat;
  logic  frame_done;
  modport source (output valid, output code_word, output is_repeat, output frame_done,
                  input ready);
  modport sink (input valid, input code_word, input is_repeat, input frame_done,
                output ready);
endinterface

interface necir_cfg_if;
  import necir_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  win_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/necir_cfg_regs.sv
// Window configuration registers of the NEC infrared pulse decoder.
module necir_cfg_regs
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  necir_cfg_if.sink   cfg_if,
  output necir_cfg_t  cfg
);

  necir_cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lead_silence_window <= RST_LEAD_SILENCE;
      cfg_r.lead_pulse_window   <= RST_LEAD_PULSE;
      cfg_r.repeat_pulse_window <= RST_REPEAT_PULSE;
      cfg_r.bit_silence_window  <= RST_BIT_SILENCE;
      cfg_r.zero_pulse_window   <= RST_ZERO_PULSE;
      cfg_r.one_pulse_window    <= RST_ONE_PULSE;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_LEAD_SILENCE: cfg_r.lead_silence_window <= cfg_if.data;
        REG_LEAD_PULSE:   cfg_r.lead_pulse_window   <= cfg_if.data;
        REG_REPEAT_PULSE: cfg_r.repeat_pulse_window <= cfg_if.data;
        REG_BIT_SILENCE:  cfg_r.bit_silence_window  <= cfg_if.data;
        REG_ZERO_PULSE:   cfg_r.zero_pulse_window   <= cfg_if.data;
        REG_ONE_PULSE:    cfg_r.one_pulse_window    <= cfg_if.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/necir_core.sv
// Input register and interval decoder of the NEC infrared pulse decoder.
module necir_core
  import necir_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tick_t         edge_time,
  input  logic          last_edge,
  input  necir_cfg_t    cfg,
  input  logic          res_ready,
  output logic          res_valid,
  output necir_result_t res
);

  localparam int unsigned BITS_W = $clog2(FRAME_BITS + 1);

  typedef enum logic [1:0] {PH_IDLE, PH_INIT, PH_SIL, PH_PUL} phase_t;

  typedef logic [BITS_W-1:0] bits_t;

  logic   stage_valid_r;
  tick_t  stage_time_r;
  logic   stage_last_r;

  phase_t phase_r, phase_nxt;
  tick_t  prev_r;
  logic   have_r;
  logic   skip_r, skip_nxt;
  code_t  shift_r, shift_nxt;
  bits_t  bits_r, bits_nxt;
  logic   rep_r, rep_nxt;
  logic   fin_r, fin_nxt;

  tick_t  delta;
  logic   go;
  logic   lead_ok;

  function automatic logic in_window(input tick_t d, input win_t win);
    return (d >= win[TICK_W-1:0]) && (d <= win[WIN_W-1:TICK_W]);
  endfunction

  assign go        = stage_valid_r && (!stage_last_r || res_ready);
  assign in_ready  = !stage_valid_r || go;
  assign res_valid = go && stage_last_r;
  assign delta     = stage_time_r - prev_r;
  assign lead_ok   = in_window(delta, cfg.lead_silence_window);

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    rep_nxt   = rep_r;
    fin_nxt   = fin_r;
    if (have_r && !fin_r) begin
      if (skip_r) begin
        skip_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (lead_ok) begin
              shift_nxt = '0;
              phase_nxt = PH_INIT;
            end else begin
              skip_nxt = 1'b1;
            end
          end
          PH_INIT: begin
            if (in_window(delta, cfg.repeat_pulse_window)) begin
              bits_nxt  = '0;
              rep_nxt   = 1'b1;
              phase_nxt = PH_SIL;
            end else if (in_window(delta, cfg.lead_pulse_window)) begin
              bits_nxt  = BITS_W'(FRAME_BITS);
              rep_nxt   = 1'b0;
              phase_nxt = PH_SIL;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_SIL: begin
            if (bits_r == '0) begin
              fin_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end else if (in_window(delta, cfg.bit_silence_window)) begin
              phase_nxt = PH_PUL;
            end else if (lead_ok) begin
              shift_nxt = '0;
              phase_nxt = PH_INIT;
            end else begin
              phase_nxt = PH_IDLE;
              skip_nxt  = 1'b1;
            end
          end
          PH_PUL: begin
            if (in_window(delta, cfg.zero_pulse_window)) begin
              shift_nxt = {shift_r[CODE_W-2:0], 1'b0};
              bits_nxt  = bits_r - 1'b1;
              phase_nxt = PH_SIL;
            end else if (in_window(delta, cfg.one_pulse_window)) begin
              shift_nxt = {shift_r[CODE_W-2:0], 1'b1};
              bits_nxt  = bits_r - 1'b1;
              phase_nxt = PH_SIL;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  assign res.code_word  = shift_nxt;
  assign res.is_repeat  = rep_nxt;
  assign res.frame_done = fin_nxt;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_time_r <= edge_time;
      stage_last_r <= last_edge;
    end
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      phase_r       <= PH_IDLE;
      prev_r        <= '0;
      have_r        <= 1'b0;
      skip_r        <= 1'b0;
      shift_r       <= '0;
      bits_r        <= '0;
      rep_r         <= 1'b0;
      fin_r         <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        stage_valid_r <= 1'b1;
      end else if (go) begin
        stage_valid_r <= 1'b0;
      end
      if (go) begin
        if (stage_last_r) begin
          phase_r <= PH_IDLE;
          prev_r  <= '0;
          have_r  <= 1'b0;
          skip_r  <= 1'b0;
          shift_r <= '0;
          bits_r  <= '0;
          rep_r   <= 1'b0;
          fin_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          prev_r  <= stage_time_r;
          have_r  <= 1'b1;
          skip_r  <= skip_nxt;
          shift_r <= shift_nxt;
          bits_r  <= bits_nxt;
          rep_r   <= rep_nxt;
          fin_r   <= fin_nxt;
        end
      end
    end
  end

endmodule

FILE: rtl/core/necir_out_buf.sv
// Result register of the NEC infrared pulse decoder.
module necir_out_buf
  import necir_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  output logic          res_ready,
  input  necir_result_t res,
  necir_out_if.source   out_if
);

  logic          out_valid_r;
  necir_result_t data_r;

  assign res_ready         = !out_valid_r || out_if.ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.code_word  = data_r.code_word;
  assign out_if.is_repeat  = data_r.is_repeat;
  assign out_if.frame_done = data_r.frame_done;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

endmodule

FILE: rtl/core/nec_ir_pulse_decoder.sv
// Top level of the NEC infrared pulse decoder.
// Takes one receiver edge timestamp per cycle and decodes the interval since the previous
// edge against six programmable min/max tick windows (prologue silence, command and repeat
// prologue pulses, bit silence, zero and one pulses). An edge is held in the input
// register, where a single pass of window compares updates the decoder and the code shift
// register; an edge marked last loads one result into the output register once that register
// can accept it, so a result passes the input register and then the output register. Sustained
// rate is one edge per cycle, limited only by the result register when the sink stalls.
// Windows may be written only while no edge is in flight.
module nec_ir_pulse_decoder
  import necir_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  necir_in_if.sink    in_if,
  necir_out_if.source out_if,
  necir_cfg_if.sink   cfg_if
);

  necir_cfg_t    cfg;
  necir_result_t res;
  logic          res_valid;
  logic          res_ready;

  necir_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  necir_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .edge_time (in_if.edge_time),
    .last_edge (in_if.last_edge),
    .cfg       (cfg),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  necir_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_if    (out_if)
  );

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_if.valid)
    else $error("result item not captured in output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !res_valid)
    else $error("result item issued while output register is stalled");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_if.ready)
    else $error("configuration write stalled");

endmodule

FILE: dv/nec_ir_pulse_decoder_test.sv
// Self-checking testbench of the NEC infrared pulse decoder: directed table, then random bursts.
`timescale 1ns / 1ps

module nec_ir_pulse_decoder_test;
  import necir_pkg::*;

  localparam int FRAME_BITS  = 32;
  localparam int PHASE_ITEMS = 105;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_COUNT   = 24;
  localparam win_t ANY_TICK  = 32'hFFFF0000;

  typedef enum logic [1:0] {PH_IDLE, PH_INIT, PH_SILENCE, PH_PULSE} dec_phase_e;
  typedef enum int {BURST_COMMAND, BURST_REPEAT, BURST_NOISE} burst_e;

  typedef struct packed {
    tick_t         delta;
    logic          last;
    logic          typed;
    necir_result_t want;
  } dir_row_t;

  localparam necir_result_t ZERO_RESULT = '0;
  localparam necir_result_t REPEAT_DONE = {32'h0, 1'b1, 1'b1};

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{16'd65535, 1'b1, 1'b1, ZERO_RESULT},
    '{16'd1,     1'b0, 1'b0, ZERO_RESULT},
    '{16'd9000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd2250,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd560,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd300,   1'b1, 1'b1, REPEAT_DONE},
    '{16'd40000, 1'b0, 1'b0, ZERO_RESULT},
    '{16'd100,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd9000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd9000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd4500,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd560,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd1690,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd9500,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd3000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd100,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd9000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd9000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd4200,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd560,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd420,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd600,   1'b0, 1'b0, ZERO_RESULT},
    '{16'd1000,  1'b0, 1'b0, ZERO_RESULT},
    '{16'd65535, 1'b1, 1'b0, ZERO_RESULT}
  };

  logic clk;
  logic rst_n;

  necir_in_if  in_ch ();
  necir_out_if out_ch ();
  necir_cfg_if cfg_ch ();

  nec_ir_pulse_decoder #(.FRAME_BITS(FRAME_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  necir_cfg_t win_cfg;
  tick_t      prev_tick;
  bit         have_tick;
  bit         skip_next;
  bit         frame_seen;
  bit         repeat_flag;
  dec_phase_e phase;
  code_t      code_acc;
  logic [5:0] bits_todo;

  necir_result_t pending_codes[$];
  tick_t tick_now;
  bit    hold_req;
  bit    quiet_sender;
  bit    sink_steady;
  int    edge_items;
  int    results_seen;
  int    reg_writes;
  int    err_count;

  initial begin
    clk = 1'b0;
    forever begin
      #1 clk = 1'b1;
      #1 clk = 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit win_hit(tick_t d, win_t w);
    return (d >= w[15:0]) && (d <= w[31:16]);
  endfunction

  function automatic tick_t pick_in(win_t w);
    int lo;
    int hi;
    lo = int'(w[15:0]);
    hi = int'(w[31:16]);
    if (lo <= hi) return tick_t'($urandom_range(hi, lo));
    return tick_t'($urandom_range(0, 65535));
  endfunction

  function automatic tick_t pick_out(win_t w);
    int lo;
    int hi;
    lo = int'(w[15:0]);
    hi = int'(w[31:16]);
    if (lo > hi) return tick_t'($urandom_range(0, 65535));
    if (lo > 0 && (hi == 65535 || $urandom_range(0, 1) == 0))
      return tick_t'($urandom_range(lo - 1, 0));
    if (hi < 65535) return tick_t'($urandom_range(65535, hi + 1));
    return tick_t'($urandom_range(0, 65535));
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_decoder();
    prev_tick   = '0;
    have_tick   = 1'b0;
    skip_next   = 1'b0;
    phase       = PH_IDLE;
    code_acc    = '0;
    bits_todo   = '0;
    repeat_flag = 1'b0;
    frame_seen  = 1'b0;
  endtask

  task automatic check_idle_gap(tick_t d);
    if (win_hit(d, win_cfg.lead_silence_window)) begin
      code_acc = '0;
      phase    = PH_INIT;
    end else begin
      skip_next = 1'b1;
    end
  endtask

  task automatic decode_interval(tick_t d);
    case (phase)
      PH_IDLE: check_idle_gap(d);
      PH_INIT: begin
        if (win_hit(d, win_cfg.repeat_pulse_window)) begin
          bits_todo   = '0;
          repeat_flag = 1'b1;
          phase       = PH_SILENCE;
        end else if (win_hit(d, win_cfg.lead_pulse_window)) begin
          bits_todo   = 6'(FRAME_BITS);
          repeat_flag = 1'b0;
          phase       = PH_SILENCE;
        end else begin
          phase = PH_IDLE;
        end
      end
      PH_SILENCE: begin
        if (bits_todo == 0) begin
          frame_seen = 1'b1;
          phase      = PH_IDLE;
        end else if (win_hit(d, win_cfg.bit_silence_window)) begin
          phase = PH_PULSE;
        end else begin
          phase = PH_IDLE;
          check_idle_gap(d);
        end
      end
      default: begin
        if (win_hit(d, win_cfg.zero_pulse_window)) begin
          code_acc  = code_acc << 1;
          bits_todo = bits_todo - 6'd1;
          phase     = PH_SILENCE;
        end else if (win_hit(d, win_cfg.one_pulse_window)) begin
          code_acc  = (code_acc << 1) | code_t'(1);
          bits_todo = bits_todo - 6'd1;
          phase     = PH_SILENCE;
        end else begin
          phase = PH_IDLE;
        end
      end
    endcase
  endtask

  task automatic predict_edge(tick_t t, logic last, output necir_result_t r, output bit has_r);
    has_r = 1'b0;
    r     = '0;
    if (have_tick && !frame_seen) begin
      if (skip_next) skip_next = 1'b0;
      else decode_interval(t - prev_tick);
    end
    prev_tick = t;
    have_tick = 1'b1;
    if (last) begin
      r.code_word  = code_acc;
      r.is_repeat  = repeat_flag;
      r.frame_done = frame_seen;
      has_r        = 1'b1;
      clear_decoder();
    end
  endtask

  task automatic send_edge(tick_t t, logic last, int gap, bit typed, necir_result_t want);
    necir_result_t r;
    bit has_r;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.edge_time <= t;
    in_ch.last_edge <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_edge(t, last, r, has_r);
    if (has_r) pending_codes.push_back(typed ? want : r);
    edge_items++;
  endtask

  task automatic emit(tick_t d, logic last);
    tick_now = tick_now + d;
    send_edge(tick_now, last, quiet_sender ? 0 : idle_len(), 1'b0, ZERO_RESULT);
  endtask

  task automatic write_window(cfg_idx_t idx, win_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LEAD_SILENCE: win_cfg.lead_silence_window = value;
      REG_LEAD_PULSE:   win_cfg.lead_pulse_window   = value;
      REG_REPEAT_PULSE: win_cfg.repeat_pulse_window = value;
      REG_BIT_SILENCE:  win_cfg.bit_silence_window  = value;
      REG_ZERO_PULSE:   win_cfg.zero_pulse_window   = value;
      REG_ONE_PULSE:    win_cfg.one_pulse_window    = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_windows(necir_cfg_t c);
    write_window(REG_LEAD_SILENCE, c.lead_silence_window);
    write_window(REG_LEAD_PULSE,   c.lead_pulse_window);
    write_window(REG_REPEAT_PULSE, c.repeat_pulse_window);
    write_window(REG_BIT_SILENCE,  c.bit_silence_window);
    write_window(REG_ZERO_PULSE,   c.zero_pulse_window);
    write_window(REG_ONE_PULSE,    c.one_pulse_window);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic gen_burst(burst_e kind, bit broken);
    win_t wins[$];
    int   bad;
    int   n_use;
    if (kind == BURST_COMMAND) begin
      wins.push_back(win_cfg.lead_silence_window);
      wins.push_back(win_cfg.lead_pulse_window);
      repeat (FRAME_BITS) begin
        wins.push_back(win_cfg.bit_silence_window);
        wins.push_back($urandom_range(0, 1) ? win_cfg.one_pulse_window
                                            : win_cfg.zero_pulse_window);
      end
    end else if (kind == BURST_REPEAT) begin
      wins.push_back(win_cfg.lead_silence_window);
      wins.push_back(win_cfg.repeat_pulse_window);
    end else begin
      repeat ($urandom_range(0, 5)) wins.push_back(ANY_TICK);
    end
    bad   = -1;
    n_use = wins.size();
    if (broken && wins.size() > 0) begin
      bad   = $urandom_range(0, wins.size() - 1);
      n_use = bad + 1 + $urandom_range(0, 2);
      if (n_use > wins.size()) n_use = wins.size();
    end else if (kind != BURST_NOISE) begin
      repeat ($urandom_range(0, 3)) wins.push_back(ANY_TICK);
      n_use = wins.size();
    end
    emit(tick_t'($urandom_range(0, 65535)), n_use == 0);
    for (int k = 0; k < n_use; k++)
      emit(k == bad ? pick_out(wins[k]) : pick_in(wins[k]), k == n_use - 1);
  endtask

  task automatic run_bursts(int count);
    int start;
    int r;
    start = edge_items;
    while (edge_items - start < count) begin
      r = $urandom_range(0, 9);
      if (r <= 2) gen_burst(BURST_COMMAND, 1'b0);
      else if (r <= 6) gen_burst(BURST_REPEAT, 1'b0);
      else if (r <= 8) gen_burst($urandom_range(0, 1) ? BURST_COMMAND : BURST_REPEAT, 1'b1);
      else gen_burst(BURST_NOISE, 1'b0);
    end
  endtask

  initial begin : sink_side
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = sink_steady ? 0 : idle_len();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    necir_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_codes.size() == 0) begin
        $display("%0t: expected no result, actual code_word %h is_repeat %b frame_done %b",
                 $time, out_ch.code_word, out_ch.is_repeat, out_ch.frame_done);
        err_count++;
      end else begin
        want = pending_codes.pop_front();
        if (out_ch.code_word !== want.code_word) begin
          $display("%0t: code_word expected %h actual %h", $time, want.code_word,
                   out_ch.code_word);
          err_count++;
        end
        if (out_ch.is_repeat !== want.is_repeat) begin
          $display("%0t: is_repeat expected %b actual %b", $time, want.is_repeat,
                   out_ch.is_repeat);
          err_count++;
        end
        if (out_ch.frame_done !== want.frame_done) begin
          $display("%0t: frame_done expected %b actual %b", $time, want.frame_done,
                   out_ch.frame_done);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    necir_cfg_t c;
    in_ch.valid     = 1'b0;
    in_ch.edge_time = '0;
    in_ch.last_edge = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_LEAD_SILENCE;
    cfg_ch.data     = '0;
    hold_req        = 1'b0;
    quiet_sender    = 1'b0;
    sink_steady     = 1'b0;
    tick_now        = '0;
    edge_items      = 0;
    results_seen    = 0;
    reg_writes      = 0;
    err_count       = 0;
    win_cfg = '{RST_LEAD_SILENCE, RST_LEAD_PULSE, RST_REPEAT_PULSE,
                RST_BIT_SILENCE, RST_ZERO_PULSE, RST_ONE_PULSE};
    clear_decoder();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_COUNT; i++) begin
      tick_now = tick_now + DIR_ROWS[i].delta;
      send_edge(tick_now, DIR_ROWS[i].last, idle_len(), DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    run_bursts(PHASE_ITEMS);
    drain();

    hold_req     = 1'b1;
    quiet_sender = 1'b1;
    repeat (24) emit(tick_t'($urandom_range(0, 65535)), 1'b1);
    quiet_sender = 1'b0;
    drain();

    c = '{{16'd1100, 16'd900}, {16'd550, 16'd450}, {16'd260, 16'd200},
          {16'd80, 16'd40}, {16'd80, 16'd40}, {16'd200, 16'd140}};
    load_windows(c);
    quiet_sender = 1'b1;
    sink_steady  = 1'b1;
    run_bursts(PHASE_ITEMS);
    drain();
    quiet_sender = 1'b0;
    sink_steady  = 1'b0;

    c = '{ANY_TICK, 32'h00000000, 32'hFFFFFFFF, ANY_TICK, 32'h0000FFFF, ANY_TICK};
    load_windows(c);
    run_bursts(PHASE_ITEMS);
    drain();

    c = '{RST_LEAD_SILENCE, RST_LEAD_PULSE, {16'd4500, 16'd2000},
          RST_BIT_SILENCE, {16'd1500, 16'd400}, {16'd2000, 16'd1000}};
    load_windows(c);
    run_bursts(PHASE_ITEMS);
    drain();

    c = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    load_windows(c);
    run_bursts(PHASE_ITEMS);
    drain();

    c = '{RST_LEAD_SILENCE, RST_LEAD_PULSE, RST_REPEAT_PULSE,
          RST_BIT_SILENCE, RST_ZERO_PULSE, RST_ONE_PULSE};
    load_windows(c);
    run_bursts(PHASE_ITEMS);
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d edge items and %0d results over six window settings,", edge_items,
             results_seen);
    $display("with %0d register writes, a long result stall and empty or full windows.",
             reg_writes);
    if (err_count == 0 && pending_codes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
